### rtl/core/abm_pkg.sv
// ----------------------------------------------------------------------------
// abm_pkg
// Shared codes, widths and control types for the allocation bitmap.
// ----------------------------------------------------------------------------
package abm_pkg;

    // Fixed field widths of the request, result and register ports.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 10;
    localparam int ACTIVE_W = 11;

    // Default sizing handed to the top level.
    localparam int MAX_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

    // Request codes.
    localparam logic [OP_W-1:0] OP_SET      = 3'd0;
    localparam logic [OP_W-1:0] OP_CLR      = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST     = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_SET = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_CLR = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_ALL  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLR_ALL  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic locate;
        logic modify;
        logic scan;
        logic sweep;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rerr;
        logic scan_done;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/abm_datapath.sv
// ----------------------------------------------------------------------------
// abm_datapath
// Flag word memory, index decode, word scan and result registers.
// ----------------------------------------------------------------------------
module abm_datapath
    import abm_pkg::*;
#(
    parameter int MAX_BITS  = MAX_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [INDEX_W-1:0]  i_bit_index,
    input  logic                i_cfg_we,
    input  logic [ACTIVE_W-1:0] i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_hit,
    output logic [INDEX_W-1:0]  o_found_index,
    output logic                o_range_error
);

    localparam int NWORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BP_W    = $clog2(WORD_BITS);
    localparam int BASE_W  = $clog2(NWORDS * WORD_BITS + 1);
    localparam int CNT_W   = $clog2(MAX_BITS + 1);
    localparam int EFF_W   = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam int LW      = ((EFF_W > BASE_W) ? EFF_W : BASE_W) + 1;
    localparam int AW_MAX  = (WA_W > INDEX_W) ? WA_W : INDEX_W;
    localparam int RECIP   = (1 << 16) / WORD_BITS;
    localparam int RECIP_W = 17;
    localparam int MUL_W   = INDEX_W + RECIP_W;
    localparam int RW      = INDEX_W + 1;

    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

    // Flag memory
    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic                 mem_we;
    logic [WA_W-1:0]      mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;
    logic [WA_W-1:0]      mem_ra;

    // Request and decode registers
    logic [ACTIVE_W-1:0] r_active;
    logic [OP_W-1:0]     r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic [INDEX_W-1:0]  r_q;
    logic [WA_W-1:0]     r_waddr;
    logic [BP_W-1:0]     r_bitpos;
    logic                r_fill;
    logic [WA_W-1:0]     r_sweep_addr;

    // Scan registers
    logic [WA_W-1:0]   r_iss_addr;
    logic [BASE_W-1:0] r_iss_base;
    logic              r_iss_done;
    logic              r_rd_vld;
    logic [BASE_W-1:0] r_chk_base;
    logic              r_chk_last;

    // Staged result and output stage
    logic               r_hit;
    logic [INDEX_W-1:0] r_found;
    logic               r_rerr;
    logic               r_out_valid;
    logic               r_o_hit;
    logic [INDEX_W-1:0] r_o_found;
    logic               r_o_rerr;

    logic [LW-1:0]        eff_l;
    logic [MUL_W-1:0]     q_prod;
    logic [RW-1:0]        qw_prod;
    logic [RW-1:0]        rem_raw;
    logic [RW-1:0]        rem_fix;
    logic                 rem_over;
    logic [INDEX_W-1:0]   q_fix;
    logic [AW_MAX-1:0]    q_ext;
    logic [WORD_BITS-1:0] bit_mask;
    logic [LW-1:0]        base_l;
    logic [LW-1:0]        span;
    logic [WORD_BITS-1:0] keep;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] rev;
    logic [WORD_BITS-1:0] iso;
    logic [BP_W-1:0]      enc;
    logic                 found;
    logic                 chk_end;
    logic [LW-1:0]        found_full;
    logic                 scan_issue;

    // Effective size: the register value, capped at the storage size.
    always_comb begin
        eff_l = (LW'(r_active) < LW'(MAX_BITS)) ? LW'(r_active) : LW'(MAX_BITS);
    end

    // Word number by reciprocal multiplication; the estimate is low by at
    // most one, which the locate step corrects.
    assign q_prod = MUL_W'(i_bit_index) * MUL_W'(RECIP);

    always_comb begin
        qw_prod  = RW'(r_q) * RW'(WORD_BITS);
        rem_raw  = RW'(r_idx) - qw_prod;
        rem_over = (rem_raw >= RW'(WORD_BITS));
        rem_fix  = rem_over ? (rem_raw - RW'(WORD_BITS)) : rem_raw;
        q_fix    = r_q + INDEX_W'(rem_over);
        q_ext    = AW_MAX'(q_fix);
    end

    // Flags are stored MSB-first within a word.
    assign bit_mask = WORD_BITS'(1) << (BP_W'(WORD_BITS - 1) - r_bitpos);

    // Candidate word for a find, limited to flags below the effective size.
    always_comb begin
        base_l = LW'(r_chk_base);
        span   = eff_l - base_l;
        if (base_l >= eff_l) begin
            keep = '0;
        end else if (span >= LW'(WORD_BITS)) begin
            keep = '1;
        end else begin
            keep = ~({WORD_BITS{1'b1}} >> span[BP_W-1:0]);
        end
        cand    = ((r_op == OP_FIND_SET) ? r_rd_data : ~r_rd_data) & keep;
        found   = |cand;
        chk_end = r_chk_last || ((base_l + LW'(WORD_BITS)) >= eff_l);
    end

    // Lowest flag index is the most significant candidate bit: reverse the
    // word, isolate its lowest set bit and encode the one-hot result.
    always_comb begin
        int k;
        for (k = 0; k < WORD_BITS; k++) begin
            rev[k] = cand[WORD_BITS-1-k];
        end
        iso = rev & (~rev + WORD_BITS'(1));
        enc = '0;
        for (k = 0; k < WORD_BITS; k++) begin
            if (iso[k]) begin
                enc = enc | BP_W'(k);
            end
        end
        found_full = base_l + LW'(enc);
    end

    assign scan_issue = i_cmd.scan && !r_iss_done;

    // Memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_sweep_addr;
        mem_wd = {WORD_BITS{r_fill}};
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
        end else if (i_cmd.modify && (r_op == OP_SET)) begin
            mem_we = 1'b1;
            mem_wa = r_waddr;
            mem_wd = r_rd_data | bit_mask;
        end else if (i_cmd.modify && (r_op == OP_CLR)) begin
            mem_we = 1'b1;
            mem_wa = r_waddr;
            mem_wd = r_rd_data & ~bit_mask;
        end
        mem_re = i_cmd.locate || scan_issue;
        mem_ra = i_cmd.locate ? q_ext[WA_W-1:0] : r_iss_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // Request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_idx <= i_bit_index;
            r_q   <= q_prod[16 +: INDEX_W];
        end
        if (i_cmd.locate) begin
            r_waddr  <= q_ext[WA_W-1:0];
            r_bitpos <= rem_fix[BP_W-1:0];
        end
        if (scan_issue) begin
            r_chk_base <= r_iss_base;
            r_chk_last <= (r_iss_addr == LAST_WORD);
        end
        if (i_cmd.load_out) begin
            r_o_hit   <= r_hit;
            r_o_found <= r_found;
            r_o_rerr  <= r_rerr;
        end
    end

    // Control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= ACTIVE_RESET;
            r_fill       <= 1'b0;
            r_sweep_addr <= '0;
            r_iss_addr   <= '0;
            r_iss_base   <= '0;
            r_iss_done   <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_found      <= '0;
            r_rerr       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_fill     <= (i_op == OP_SET_ALL);
                r_iss_addr <= '0;
                r_iss_base <= '0;
                r_iss_done <= 1'b0;
                r_rd_vld   <= 1'b0;
                r_hit      <= 1'b0;
                r_found    <= '0;
                r_rerr     <= ((i_op == OP_SET) || (i_op == OP_CLR) || (i_op == OP_TEST))
                              && (LW'(i_bit_index) >= eff_l);
            end else begin
                r_rd_vld <= scan_issue;
            end
            if (i_cmd.sweep) begin
                r_sweep_addr <= (r_sweep_addr == LAST_WORD) ? '0 : r_sweep_addr + WA_W'(1);
            end
            if (scan_issue) begin
                r_iss_addr <= r_iss_addr + WA_W'(1);
                r_iss_base <= r_iss_base + BASE_W'(WORD_BITS);
                r_iss_done <= (r_iss_addr == LAST_WORD);
            end
            if (i_cmd.modify && (r_op == OP_TEST)) begin
                r_hit <= |(r_rd_data & bit_mask);
            end
            if (i_cmd.scan && r_rd_vld && (found || chk_end)) begin
                r_hit   <= found;
                r_found <= found ? found_full[INDEX_W-1:0] : '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.rerr       = r_rerr;
        o_stat.scan_done  = r_rd_vld && (found || chk_end);
        o_stat.sweep_last = (r_sweep_addr == LAST_WORD);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_found_index = r_o_found;
    assign o_range_error = r_o_rerr;

    // A word update always follows the read of that word.
    a_modify_after_locate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.modify |-> $past(i_cmd.locate))
        else $error("word update without a preceding read");

    // The sweep wraps back to the first word after the last.
    a_sweep_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && o_stat.sweep_last) |=> (r_sweep_addr == '0))
        else $error("sweep address did not wrap");

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.load_out)
        else $error("result register overwritten while stalled");

endmodule

### rtl/core/abm_ctrl.sv
// ----------------------------------------------------------------------------
// abm_ctrl
// Request sequencer: reset clearing pass, bit access, find scan and sweeps.
// ----------------------------------------------------------------------------
module abm_ctrl
    import abm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_in_stall,
    input  t_stat           i_stat,
    output t_cmd            o_cmd
);

    localparam logic [2:0] ST_SWEEP  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOCATE = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_sweep_item;
    logic       n_sweep_item;
    logic       accept;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_sweep_item = r_sweep_item;
        case (r_state)
            ST_SWEEP: begin
                if (i_stat.sweep_last) begin
                    n_state = r_sweep_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_SET, OP_CLR, OP_TEST: n_state = ST_LOCATE;
                        OP_FIND_SET, OP_FIND_CLR: n_state = ST_SCAN;
                        OP_SET_ALL, OP_CLR_ALL: begin
                            n_state      = ST_SWEEP;
                            n_sweep_item = 1'b1;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOCATE: begin
                // An out-of-range index leaves the flags untouched.
                n_state = i_stat.rerr ? ST_DONE : ST_MODIFY;
            end
            ST_MODIFY: n_state = ST_DONE;
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_item <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_item <= n_sweep_item;
        end
    end

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.locate   = (r_state == ST_LOCATE) && !i_stat.rerr;
        o_cmd.modify   = (r_state == ST_MODIFY);
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.sweep    = (r_state == ST_SWEEP);
        o_cmd.load_out = (r_state == ST_DONE) && i_stat.out_free;
    end

    // A find request goes straight to the word scan.
    a_find_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_op == OP_FIND_SET) || (i_op == OP_FIND_CLR)))
        |=> (r_state == ST_SCAN))
        else $error("find request did not start a scan");

    // Locating a flag is followed by its update or by the result.
    a_locate_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOCATE) |=> ((r_state == ST_MODIFY) || (r_state == ST_DONE)))
        else $error("unexpected state after locate");

    // Reset and fill sweeps end with the last word.
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && !i_stat.sweep_last) |=> (r_state == ST_SWEEP))
        else $error("sweep left early");

endmodule

### rtl/core/allocation_bitmap_find_first.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first
// Allocation bitmap with set, clear, test, set all, clear all and
// find-first-set / find-first-clear below a configurable active size.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_stall    i_op, i_bit_index
//  result    out        o_out_valid / i_out_stall  o_hit, o_found_index,
//                                                  o_range_error
//  config    in         i_cfg_we                   i_cfg_data (active size)
//
//  One request is in flight at a time. Set, clear and test pass through decode, read, update
//  and the result register (an out-of-range index skips the read and update); an unused code
//  goes straight to the result. Find scans at most MAX_BITS/WORD_BITS words (16 by default);
//  set all and clear all sweep every word. After reset a clearing pass over every word runs
//  before the first request is taken. A stalled result holds the next result back, but a
//  new request is taken while the previous result waits.
// ----------------------------------------------------------------------------
module allocation_bitmap_find_first
    import abm_pkg::*;
#(
    parameter int MAX_BITS  = MAX_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [INDEX_W-1:0]  i_bit_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic [INDEX_W-1:0]  o_found_index,
    output logic                o_range_error,
    input  logic                i_cfg_we,
    input  logic [ACTIVE_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    abm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    abm_datapath #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_bit_index   (i_bit_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_found_index (o_found_index),
        .o_range_error (o_range_error)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the allocation bitmap. Requests are queued by a
// stimulus process and sent by a clocked driver in bursts, with random gaps
// in most phases. A clocked monitor checks every result transfer against a
// shadow copy of the flags. The active size is changed between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import abm_pkg::*;

    localparam int WORDS       = MAX_BITS_DEF / WORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 24;

    // Request code that the block does not define.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] bit_index;
    } t_flag_request;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] found_index;
        logic               range_error;
    } t_flag_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op;
    logic [INDEX_W-1:0]  i_bit_index;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_hit;
    logic [INDEX_W-1:0]  o_found_index;
    logic                o_range_error;
    logic                i_cfg_we;
    logic [ACTIVE_W-1:0] i_cfg_data;

    t_flag_request queued_requests[$];
    t_flag_result  owed_results[$];

    // Shadow copy of the flags and of the active size register.
    logic [WORD_BITS_DEF-1:0] shadow_words[WORDS];
    logic [ACTIVE_W-1:0]      shadow_active;

    int mismatches;
    int cycle_count;
    bit sender_gappy;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int burst_left;
    int gap_left;

    allocation_bitmap_find_first dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_bit_index   (i_bit_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_found_index (o_found_index),
        .o_range_error (o_range_error),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int usable_flags();
        return (shadow_active < MAX_BITS_DEF) ? int'(shadow_active) : MAX_BITS_DEF;
    endfunction

    // Applies one request to the shadow flags and returns the answer it earns.
    function automatic t_flag_result bitmap_answer(t_flag_request req);
        t_flag_result ans;
        int           limit;
        int           w;
        int           pos;
        logic         want;
        ans   = '0;
        limit = usable_flags();
        w     = req.bit_index / WORD_BITS_DEF;
        pos   = WORD_BITS_DEF - 1 - (req.bit_index % WORD_BITS_DEF);
        case (req.op)
            OP_SET, OP_CLR, OP_TEST: begin
                if (int'(req.bit_index) >= limit) begin
                    ans.range_error = 1'b1;
                end else if (req.op == OP_SET) begin
                    shadow_words[w][pos] = 1'b1;
                end else if (req.op == OP_CLR) begin
                    shadow_words[w][pos] = 1'b0;
                end else begin
                    ans.hit = shadow_words[w][pos];
                end
            end
            OP_FIND_SET, OP_FIND_CLR: begin
                want = (req.op == OP_FIND_SET);
                for (int i = 0; i < limit && !ans.hit; i++) begin
                    if (shadow_words[i / WORD_BITS_DEF][WORD_BITS_DEF - 1 - (i % WORD_BITS_DEF)]
                            == want) begin
                        ans.hit         = 1'b1;
                        ans.found_index = i[INDEX_W-1:0];
                    end
                end
            end
            OP_SET_ALL: begin
                foreach (shadow_words[k]) shadow_words[k] = '1;
            end
            OP_CLR_ALL: begin
                foreach (shadow_words[k]) shadow_words[k] = '0;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Driver: bursts of requests, separated by random gaps when the sender is gappy.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_op        <= OP_TEST;
            i_bit_index <= '0;
            burst_left  = 1;
            gap_left    = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                owed_results.push_back(bitmap_answer('{op: i_op, bit_index: i_bit_index}));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    t_flag_request req;
                    req = queued_requests.pop_front();
                    i_op        <= req.op;
                    i_bit_index <= req.bit_index;
                    i_in_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        if (sender_gappy)
                            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                                   : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_served = 0;
            hold_left   = 0;
        end else begin
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Monitor: every result transfer is checked against the oldest answer owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with none owed: hit %0b index %0d range %0b",
                         $time, o_hit, o_found_index, o_range_error);
                mismatches++;
            end else begin
                t_flag_result want;
                want = owed_results.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    mismatches++;
                end
                if (o_found_index !== want.found_index) begin
                    $display("%0t: found_index expected %0d actual %0d",
                             $time, want.found_index, o_found_index);
                    mismatches++;
                end
                if (o_range_error !== want.range_error) begin
                    $display("%0t: range_error expected %0b actual %0b",
                             $time, want.range_error, o_range_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_req(logic [OP_W-1:0] op, int idx);
        t_flag_request req;
        req.op        = op;
        req.bit_index = idx[INDEX_W-1:0];
        queued_requests.push_back(req);
    endtask

    // Favours indices around the active size and around word boundaries.
    function automatic int pick_index();
        int limit;
        int k;
        int v;
        limit = usable_flags();
        k     = $urandom_range(0, 9);
        if (k < 2)
            v = $urandom_range(0, 1023);
        else if (k < 5)
            v = $urandom_range(0, (limit > 0) ? limit - 1 : 0);
        else if (k < 8)
            v = limit - 3 + $urandom_range(0, 5);
        else
            v = $urandom_range(0, WORDS - 1) * WORD_BITS_DEF + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 25) return OP_SET;
        if (k < 45) return OP_CLR;
        if (k < 60) return OP_TEST;
        if (k < 75) return OP_FIND_SET;
        if (k < 90) return OP_FIND_CLR;
        if (k < 94) return OP_SET_ALL;
        if (k < 98) return OP_CLR_ALL;
        return OP_UNUSED;
    endfunction

    // Mostly fill-then-search sequences with random holes, the rest loose
    // requests.
    task automatic push_random(int count);
        int               n;
        int               holes;
        logic [OP_W-1:0]  fill;
        logic [OP_W-1:0]  op;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 4) begin
                fill  = $urandom_range(0, 1) ? OP_SET_ALL : OP_CLR_ALL;
                holes = $urandom_range(1, 4);
                push_req(fill, $urandom_range(0, 1023));
                for (int h = 0; h < holes; h++)
                    push_req((fill == OP_SET_ALL) ? OP_CLR : OP_SET, pick_index());
                push_req((fill == OP_SET_ALL) ? OP_FIND_CLR : OP_FIND_SET,
                         $urandom_range(0, 1023));
                push_req(OP_TEST, pick_index());
                push_req((fill == OP_SET_ALL) ? OP_FIND_SET : OP_FIND_CLR,
                         $urandom_range(0, 1023));
                n += holes + 4;
            end else begin
                op = pick_op();
                if (op == OP_SET || op == OP_CLR || op == OP_TEST)
                    push_req(op, pick_index());
                else
                    push_req(op, $urandom_range(0, 1023));
                n++;
            end
        end
    endtask

    // The sender pauses here until every answer owed has been delivered.
    task automatic wait_idle();
        while (queued_requests.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active(int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[ACTIVE_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_active = value[ACTIVE_W-1:0];
    endtask

    initial begin
        int sizes[11];
        sizes = '{1024, 1, 64, 63, 65, 0, 2047, 1000, 512, 0, 1024};
        sizes[9] = $urandom_range(2, 1023);
        mismatches    = 0;
        cycle_count   = 0;
        hold_requests = 0;
        sender_gappy  = 1'b1;
        stall_pct     = 30;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_TEST;
        i_bit_index   = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_active = ACTIVE_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset size.
        push_req(OP_TEST, 0);
        push_req(OP_FIND_SET, 0);
        push_req(OP_SET, 0);
        push_req(OP_SET, 1023);
        push_req(OP_TEST, 0);
        push_req(OP_TEST, 1023);
        push_req(OP_FIND_SET, 1023);
        push_req(OP_CLR, 0);
        push_req(OP_FIND_SET, 0);
        push_req(OP_FIND_CLR, 0);
        push_req(OP_SET_ALL, 0);
        push_req(OP_FIND_CLR, 0);
        push_req(OP_FIND_SET, 0);
        push_req(OP_CLR, 1023);
        push_req(OP_FIND_CLR, 0);
        push_req(OP_CLR, 64);
        push_req(OP_CLR, 63);
        push_req(OP_FIND_CLR, 0);
        push_req(OP_CLR_ALL, 1023);
        push_req(OP_FIND_SET, 0);
        push_req(OP_SET, 64);
        push_req(OP_FIND_SET, 0);
        push_req(OP_UNUSED, 1023);
        push_req(OP_TEST, 64);
        wait_idle();

        for (int phase = 0; phase < 11; phase++) begin
            if (phase > 0)
                write_active(sizes[phase]);
            if (phase % 4 == 1) begin
                sender_gappy = 1'b0;
                stall_pct    = 0;
            end else begin
                sender_gappy = 1'b1;
                stall_pct    = $urandom_range(10, 60);
            end
            if (sizes[phase] < 64) begin
                // Out of range near a tiny or empty bitmap.
                push_req(OP_SET, sizes[phase]);
                push_req(OP_TEST, 1023);
                push_req(OP_FIND_CLR, 0);
            end
            push_random(75);
            // Hold the result side long enough for the block to back up.
            if (phase % 3 == 0)
                hold_requests++;
            wait_idle();
            push_random(75);
            wait_idle();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/abm_pkg.sv
rtl/core/abm_datapath.sv
rtl/core/abm_ctrl.sv
rtl/core/allocation_bitmap_find_first.sv
dv/testbench.sv
